// ----- src/fvu_pkg.sv -----
// shared types, constants and helper functions of the camera view block
package fvu_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int TRIG_ITER    = 16;
  localparam int ATAN_COUNT   = 24;
  localparam int CORDIC_STEPS = (TRIG_ITER < ATAN_COUNT) ? TRIG_ITER : ATAN_COUNT;
  localparam logic signed [32:0] CORDIC_START = 33'sd652032874;

  localparam logic CFG_PITCH_MIN = 1'b0;
  localparam logic CFG_PITCH_MAX = 1'b1;

  localparam int IN_DATA_W  = 176;
  localparam int OUT_DATA_W = 280;

  typedef enum logic [2:0] {
    OP_SET_POS    = 3'd0,
    OP_MOVE_VEC   = 3'd1,
    OP_MOVE_FWD   = 3'd2,
    OP_MOVE_RIGHT = 3'd3,
    OP_SET_ANG    = 3'd4,
    OP_ROTATE     = 3'd5,
    OP_NONE       = 3'd6
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] ang_p;
    logic signed [15:0] ang_y;
    logic signed [15:0] ang_r;
    logic signed [31:0] amount;
  } cmd_t;

  // arctangent of 2^-i in 2^-32 turns
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v > 40'sd2147483647) r = 32'sh7fff_ffff;
    else if (v < -40'sd2147483648) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ----- src/fly_camera_view_update_core.sv -----
// top level of the first person camera view block
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+-----------------------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | command word, kind in tuser
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | one view matrix row, tlast on row 3
//  cfg       | in        | cfg_we_i                     | pitch limit registers
//
// each command runs from the queue head through the 16 step cordic and the single
// shared 32x32 multiplier (4 matrix and 9 translation products, and first the move
// products of a forward or right move) to its four rows, which are held while
// m_axis_tready is low; a two word command queue keeps taking commands, until it
// is full, while rows wait on m_axis
// asynchronous active low reset zeroes position, angles and vectors, limits go to
// minus and plus a quarter turn
module fly_camera_view_update_core import fvu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pos_x, pos_y, pos_z, angle_pitch, angle_yaw, angle_roll, move_amount
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic [2:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // row_index, col_zero, col_one, col_two, col_three, cur_x, cur_y, cur_z,
  // cur_pitch, cur_yaw, cur_roll, zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // last_row
  output logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [14:0]           cfg_wdata_i
);

  // pitch limit registers
  logic signed [14:0] pitch_min_q;
  logic [14:0]        pitch_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_min_q <= -15'sd16384;
      pitch_max_q <= 15'd16384;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PITCH_MIN: pitch_min_q <= signed'(cfg_wdata_i);
        default:       pitch_max_q <= cfg_wdata_i;
      endcase
    end
  end

  // queue between intake and execution
  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  fvu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  // state update, trig, matrix and row output
  fvu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .pitch_min_i (pitch_min_q),
    .pitch_max_i (pitch_max_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ----- src/fvu_front.sv -----
// command intake: decode of the request kind and a two word command queue
module fvu_front import fvu_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_DATA_W-1:0] s_axis_tdata,
  input  logic [2:0]           s_axis_tuser,
  output logic                 cmd_valid_o,
  output cmd_t                 cmd_o,
  input  logic                 cmd_pop_i
);

  cmd_t       ent_q [2];
  logic [1:0] count_q, count_d;
  logic       wr_q, rd_q;
  logic       push;
  cmd_t       cmd_in;

  always_comb begin
    unique case (s_axis_tuser)
      3'd0:    cmd_in.op = OP_SET_POS;
      3'd1:    cmd_in.op = OP_MOVE_VEC;
      3'd2:    cmd_in.op = OP_MOVE_FWD;
      3'd3:    cmd_in.op = OP_MOVE_RIGHT;
      3'd4:    cmd_in.op = OP_SET_ANG;
      3'd5:    cmd_in.op = OP_ROTATE;
      default: cmd_in.op = OP_NONE;
    endcase
    cmd_in.pos_x  = s_axis_tdata[31:0];
    cmd_in.pos_y  = s_axis_tdata[63:32];
    cmd_in.pos_z  = s_axis_tdata[95:64];
    cmd_in.ang_p  = s_axis_tdata[111:96];
    cmd_in.ang_y  = s_axis_tdata[127:112];
    cmd_in.ang_r  = s_axis_tdata[143:128];
    cmd_in.amount = s_axis_tdata[175:144];
  end

  assign s_axis_tready = (count_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign cmd_valid_o   = (count_q != 2'd0);
  assign cmd_o         = ent_q[rd_q];

  always_comb begin
    count_d = count_q;
    if (push && !cmd_pop_i) count_d = count_q + 2'd1;
    else if (!push && cmd_pop_i) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) wr_q <= ~wr_q;
      if (cmd_pop_i) rd_q <= ~rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_q] <= cmd_in;
  end

endmodule

// ----- src/fvu_back.sv -----
// command execution: state update, cordic sine and cosine, matrix and row output
module fvu_back import fvu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  input  cmd_t                  cmd_i,
  output logic                  cmd_pop_o,
  input  logic signed [14:0]    pitch_min_i,
  input  logic [14:0]           pitch_max_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_last_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_UPDATE = 4'd1;
  localparam logic [3:0] ST_MV_MUL = 4'd2;
  localparam logic [3:0] ST_MV_ADD = 4'd3;
  localparam logic [3:0] ST_C_INIT = 4'd4;
  localparam logic [3:0] ST_CORDIC = 4'd5;
  localparam logic [3:0] ST_QUAD   = 4'd6;
  localparam logic [3:0] ST_M_MUL  = 4'd7;
  localparam logic [3:0] ST_M_RND  = 4'd8;
  localparam logic [3:0] ST_T_MUL  = 4'd9;
  localparam logic [3:0] ST_T_ACC  = 4'd10;
  localparam logic [3:0] ST_OUT    = 4'd11;

  logic [3:0] state_q;
  logic [1:0] k_q, r_q, mi_q, orow_q;
  logic [4:0] it_q;
  cmd_t       cmd_q;

  logic signed [31:0] pos_x_q, pos_y_q, pos_z_q;
  logic signed [15:0] pitch_q, yaw_q, roll_q;
  logic signed [15:0] fwd0_q, fwd1_q, fwd2_q, rgt0_q, rgt1_q, rgt2_q;

  logic signed [32:0] px_q, py_q, pz_q, yx_q, yy_q, yz_q;
  logic [1:0]         qp_q, qy_q;
  logic signed [31:0] ca_q, sa_q, cb_q, sb_q, m10_q, m12_q, m20_q, m22_q;
  logic signed [31:0] t0_q, t1_q, t2_q;
  logic signed [35:0] t_q;
  logic signed [63:0] prod_q;

  // shared multiplier
  logic signed [31:0] mul_a, mul_b;
  logic signed [31:0] mat [9];
  logic signed [31:0] pos_sel;
  logic signed [15:0] vec_sel;

  always_comb begin
    mat[0] = cb_q;  mat[1] = 32'sd0; mat[2] = sb_q;
    mat[3] = m10_q; mat[4] = ca_q;   mat[5] = m12_q;
    mat[6] = m20_q; mat[7] = sa_q;   mat[8] = m22_q;
    case (k_q)
      2'd0:    pos_sel = pos_x_q;
      2'd1:    pos_sel = pos_y_q;
      default: pos_sel = pos_z_q;
    endcase
    if (cmd_q.op == OP_MOVE_FWD) begin
      case (k_q)
        2'd0:    vec_sel = fwd0_q;
        2'd1:    vec_sel = fwd1_q;
        default: vec_sel = fwd2_q;
      endcase
    end else begin
      case (k_q)
        2'd0:    vec_sel = rgt0_q;
        2'd1:    vec_sel = rgt1_q;
        default: vec_sel = rgt2_q;
      endcase
    end
    mul_a = 32'sd0;
    mul_b = 32'sd0;
    case (state_q)
      ST_MV_MUL: begin
        mul_a = 32'(vec_sel);
        mul_b = cmd_q.amount;
      end
      ST_M_MUL: begin
        mul_a = mi_q[1] ? ca_q : sa_q;
        mul_b = mi_q[0] ? cb_q : sb_q;
      end
      ST_T_MUL: begin
        mul_a = mat[4'(r_q) * 4'd3 + 4'(k_q)];
        mul_b = pos_sel;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // rounded products
  logic signed [63:0] mv_round, r30_round;
  logic signed [39:0] mv_sum;
  logic signed [33:0] r30;
  logic signed [35:0] t_new;
  assign mv_round  = (prod_q + 64'sd8192) >>> 14;
  assign mv_sum    = 40'(pos_sel) + mv_round[39:0];
  assign r30_round = (prod_q + 64'sd536870912) >>> 30;
  assign r30       = r30_round[33:0];
  assign t_new     = t_q + 36'(r30);

  // pitch clamp, the upper limit applied last
  logic signed [16:0] p_raw, p_lim, pmin17, pmax17;
  assign pmin17 = 17'(pitch_min_i);
  assign pmax17 = signed'({2'b00, pitch_max_i});
  always_comb begin
    if (cmd_q.op == OP_SET_ANG) p_raw = 17'(cmd_q.ang_p);
    else p_raw = 17'(pitch_q) + 17'(cmd_q.ang_p);
    p_lim = p_raw;
    if (p_lim < pmin17) p_lim = pmin17;
    if (p_lim > pmax17) p_lim = pmax17;
  end

  // quarter turn reduction of an angle into a cordic start phase
  function automatic logic [34:0] reduce(input logic signed [15:0] ang);
    logic [31:0] ph, rem;
    logic [1:0]  q;
    ph  = 32'(32'(ang) << (32 - ANGLE_BITS));
    q   = 2'((ph + 32'h2000_0000) >> 30);
    rem = ph - {q, 30'd0};
    return {q, rem[31], rem};
  endfunction

  logic [34:0] red_p, red_y;
  assign red_p = reduce(pitch_q);
  assign red_y = reduce(yaw_q);

  logic [31:0] atan_i;
  assign atan_i = atan_turn(it_q);

  logic signed [32:0] pdx, pdy, ydx, ydy, atan33;
  assign pdx    = py_q >>> it_q;
  assign pdy    = px_q >>> it_q;
  assign ydx    = yy_q >>> it_q;
  assign ydy    = yx_q >>> it_q;
  assign atan33 = signed'({1'b0, atan_i});

  function automatic logic [63:0] quad_fix(input logic [1:0] q,
                                           input logic signed [32:0] x,
                                           input logic signed [32:0] y);
    logic signed [32:0] c, s;
    case (q)
      2'd0:    begin c = x;  s = y;  end
      2'd1:    begin c = -y; s = x;  end
      2'd2:    begin c = -x; s = -y; end
      default: begin c = y;  s = -x; end
    endcase
    return {c[31:0], s[31:0]};
  endfunction

  logic [63:0] cs_p, cs_y;
  assign cs_p = quad_fix(qp_q, px_q, py_q);
  assign cs_y = quad_fix(qy_q, yx_q, yy_q);

  // vector update from rows 2 and 0 of the rotation
  function automatic logic signed [15:0] to_q14(input logic signed [32:0] v);
    logic signed [32:0] s;
    s = (v + 33'sd32768) >>> 16;
    return s[15:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= 2'd0;
      r_q     <= 2'd0;
      mi_q    <= 2'd0;
      orow_q  <= 2'd0;
      it_q    <= 5'd0;
      pos_x_q <= '0; pos_y_q <= '0; pos_z_q <= '0;
      pitch_q <= '0; yaw_q <= '0; roll_q <= '0;
      fwd0_q  <= '0; fwd1_q <= '0; fwd2_q <= '0;
      rgt0_q  <= '0; rgt1_q <= '0; rgt2_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) state_q <= ST_UPDATE;
        end
        ST_UPDATE: begin
          state_q <= ST_C_INIT;
          case (cmd_q.op)
            OP_SET_POS: begin
              pos_x_q <= cmd_q.pos_x;
              pos_y_q <= cmd_q.pos_y;
              pos_z_q <= cmd_q.pos_z;
            end
            OP_MOVE_VEC: begin
              pos_x_q <= sat32(40'(pos_x_q) + 40'(cmd_q.pos_x));
              pos_y_q <= sat32(40'(pos_y_q) + 40'(cmd_q.pos_y));
              pos_z_q <= sat32(40'(pos_z_q) + 40'(cmd_q.pos_z));
            end
            OP_MOVE_FWD, OP_MOVE_RIGHT: begin
              k_q     <= 2'd0;
              state_q <= ST_MV_MUL;
            end
            OP_SET_ANG: begin
              pitch_q <= p_lim[15:0];
              yaw_q   <= cmd_q.ang_y;
              roll_q  <= cmd_q.ang_r;
            end
            OP_ROTATE: begin
              pitch_q <= p_lim[15:0];
              yaw_q   <= yaw_q + cmd_q.ang_y;
              roll_q  <= roll_q + cmd_q.ang_r;
            end
            default: ;
          endcase
        end
        ST_MV_MUL: state_q <= ST_MV_ADD;
        ST_MV_ADD: begin
          case (k_q)
            2'd0:    pos_x_q <= sat32(mv_sum);
            2'd1:    pos_y_q <= sat32(mv_sum);
            default: pos_z_q <= sat32(mv_sum);
          endcase
          if (k_q == 2'd2) begin
            state_q <= ST_C_INIT;
          end else begin
            k_q     <= k_q + 2'd1;
            state_q <= ST_MV_MUL;
          end
        end
        ST_C_INIT: begin
          it_q    <= 5'd0;
          state_q <= ST_CORDIC;
        end
        ST_CORDIC: begin
          it_q <= it_q + 5'd1;
          if (it_q == 5'(CORDIC_STEPS - 1)) state_q <= ST_QUAD;
        end
        ST_QUAD: begin
          mi_q    <= 2'd0;
          state_q <= ST_M_MUL;
        end
        ST_M_MUL: state_q <= ST_M_RND;
        ST_M_RND: begin
          mi_q <= mi_q + 2'd1;
          if (mi_q == 2'd3) begin
            r_q     <= 2'd0;
            k_q     <= 2'd0;
            state_q <= ST_T_MUL;
          end else begin
            state_q <= ST_M_MUL;
          end
        end
        ST_T_MUL: state_q <= ST_T_ACC;
        ST_T_ACC: begin
          state_q <= ST_T_MUL;
          if (k_q == 2'd2) begin
            k_q <= 2'd0;
            if (r_q == 2'd2) begin
              fwd0_q  <= to_q14(33'(m20_q));
              fwd1_q  <= to_q14(33'(sa_q));
              fwd2_q  <= to_q14(33'(m22_q));
              rgt0_q  <= to_q14(-33'(cb_q));
              rgt1_q  <= to_q14(33'sd0);
              rgt2_q  <= to_q14(-33'(sb_q));
              orow_q  <= 2'd0;
              state_q <= ST_OUT;
            end else begin
              r_q <= r_q + 2'd1;
            end
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            orow_q <= orow_q + 2'd1;
            if (orow_q == 2'd3) state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_i;
    if (state_q == ST_C_INIT) begin
      px_q <= CORDIC_START; py_q <= '0; pz_q <= signed'(red_p[32:0]);
      yx_q <= CORDIC_START; yy_q <= '0; yz_q <= signed'(red_y[32:0]);
      qp_q <= red_p[34:33];
      qy_q <= red_y[34:33];
    end
    if (state_q == ST_CORDIC) begin
      if (!pz_q[32]) begin
        px_q <= px_q - pdx; py_q <= py_q + pdy; pz_q <= pz_q - atan33;
      end else begin
        px_q <= px_q + pdx; py_q <= py_q - pdy; pz_q <= pz_q + atan33;
      end
      if (!yz_q[32]) begin
        yx_q <= yx_q - ydx; yy_q <= yy_q + ydy; yz_q <= yz_q - atan33;
      end else begin
        yx_q <= yx_q + ydx; yy_q <= yy_q - ydy; yz_q <= yz_q + atan33;
      end
    end
    if (state_q == ST_QUAD) begin
      ca_q <= cs_p[63:32]; sa_q <= cs_p[31:0];
      cb_q <= cs_y[63:32]; sb_q <= cs_y[31:0];
    end
    if (state_q == ST_M_RND) begin
      case (mi_q)
        2'd0:    m10_q <= r30[31:0];
        2'd1:    m12_q <= -r30[31:0];
        2'd2:    m20_q <= -r30[31:0];
        default: m22_q <= r30[31:0];
      endcase
    end
    if (state_q == ST_M_RND) t_q <= '0;
    if (state_q == ST_T_ACC) begin
      if (k_q == 2'd2) begin
        t_q <= '0;
        case (r_q)
          2'd0:    t0_q <= sat32(40'(t_new));
          2'd1:    t1_q <= sat32(40'(t_new));
          default: t2_q <= sat32(40'(t_new));
        endcase
      end else begin
        t_q <= t_new;
      end
    end
  end

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;

  // output row
  logic signed [31:0] e0, e1, e2, e3;
  function automatic logic signed [31:0] to_q16(input logic signed [31:0] m);
    logic signed [32:0] s;
    s = (33'(m) + 33'sd8192) >>> 14;
    return s[31:0];
  endfunction

  always_comb begin
    case (orow_q)
      2'd0: begin
        e0 = to_q16(mat[0]); e1 = to_q16(mat[1]); e2 = to_q16(mat[2]); e3 = t0_q;
      end
      2'd1: begin
        e0 = to_q16(mat[3]); e1 = to_q16(mat[4]); e2 = to_q16(mat[5]); e3 = t1_q;
      end
      2'd2: begin
        e0 = to_q16(mat[6]); e1 = to_q16(mat[7]); e2 = to_q16(mat[8]); e3 = t2_q;
      end
      default: begin
        e0 = 32'sd0; e1 = 32'sd0; e2 = 32'sd0; e3 = 32'sd65536;
      end
    endcase
  end

  assign out_valid_o = (state_q == ST_OUT);
  assign out_last_o  = (orow_q == 2'd3);
  assign out_data_o  = {6'd0, roll_q, yaw_q, pitch_q, pos_z_q, pos_y_q, pos_x_q,
                        e3, e2, e1, e0, orow_q};

endmodule

// ----- src/fvu_checker.sv -----
// port level checks of the camera view block and their binding
module fvu_checker import fvu_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  logic out_acc;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // tlast marks row 3 and only row 3
  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[1:0] == 2'd3)))
    else $error("tlast does not match row index");

  // rows of a run follow back to back in order
  a_row_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !m_axis_tlast |=> m_axis_tvalid &&
      (m_axis_tdata[1:0] == $past(m_axis_tdata[1:0]) + 2'd1))
    else $error("row sequence broken");

  // camera state is the same on all rows of a run
  a_state_same: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !m_axis_tlast |=> $stable(m_axis_tdata[273:130]))
    else $error("camera state changed inside a run");

  // last row is the fixed homogeneous row
  a_row3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata[97:2] == 96'd0) &&
      (m_axis_tdata[129:98] == 32'd65536))
    else $error("row 3 is not 0 0 0 1");

  // a row offered is held until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("row dropped while stalled");

endmodule

bind fly_camera_view_update_core fvu_checker u_fvu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
